FILE: src/rcld_pkg.sv
// Shared types, constants, microcode table and digit helpers for the radix converter.
package rcld_pkg;

  // Field and datapath widths
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned ACC_W   = 12;
  localparam int unsigned QUO_W   = 6;
  localparam int unsigned BIT_W   = 3;

  // Base limits
  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd62;
  localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 6'd10;
  localparam logic [BASE_W-1:0] TARGET_BASE_RST = 6'd2;

  // Configuration register indexes
  localparam logic REG_SOURCE_BASE = 1'b0;
  localparam logic REG_TARGET_BASE = 1'b1;

  // Alphabet anchors
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPA   = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPZ   = 7'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOA   = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOZ   = 7'h7A;
  localparam logic [CHAR_W-1:0] UPPER_OFS  = 7'd55;  // 'A' - 10
  localparam logic [CHAR_W-1:0] LOWER_OFS  = 7'd61;  // 'a' - 36
  localparam logic [DIGIT_W-1:0] LAST_DECIMAL = 6'd9;
  localparam logic [DIGIT_W-1:0] LAST_UPPER   = 6'd35;

  // Microcode step addresses
  typedef enum logic [3:0] {
    STEP_IDLE     = 4'd0,
    STEP_PASS     = 4'd1,
    STEP_LOAD     = 4'd2,
    STEP_DIV      = 4'd3,
    STEP_STORE    = 4'd4,
    STEP_ENDPASS  = 4'd5,
    STEP_OUT_RD   = 4'd6,
    STEP_OUT_WAIT = 4'd7,
    STEP_OUT_PUSH = 4'd8,
    STEP_FINISH   = 4'd9
  } upc_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_PASS_INIT,
    OP_LOAD,
    OP_DIV,
    OP_STORE,
    OP_END_PASS,
    OP_OUT_RD,
    OP_PUSH,
    OP_FINISH
  } uop_t;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    C_NEVER,
    C_NOT_START,
    C_DIV_MORE,
    C_MORE_DIGITS,
    C_PASS_AGAIN,
    C_OUT_FULL,
    C_MORE_OUT,
    C_ALWAYS
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic div_more;
    logic more_digits;
    logic pass_again;
    logic out_full;
    logic more_out;
  } status_t;

  // Microprogram
  function automatic uword_t ucode(input upc_t step);
    uword_t w;
    w.op     = OP_NOP;
    w.cond   = C_ALWAYS;
    w.target = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w.op = OP_ACCEPT;     w.cond = C_NOT_START;   w.target = STEP_IDLE;
      end
      STEP_PASS: begin
        w.op = OP_PASS_INIT;  w.cond = C_NEVER;       w.target = STEP_IDLE;
      end
      STEP_LOAD: begin
        w.op = OP_LOAD;       w.cond = C_NEVER;       w.target = STEP_IDLE;
      end
      STEP_DIV: begin
        w.op = OP_DIV;        w.cond = C_DIV_MORE;    w.target = STEP_DIV;
      end
      STEP_STORE: begin
        w.op = OP_STORE;      w.cond = C_MORE_DIGITS; w.target = STEP_LOAD;
      end
      STEP_ENDPASS: begin
        w.op = OP_END_PASS;   w.cond = C_PASS_AGAIN;  w.target = STEP_PASS;
      end
      STEP_OUT_RD: begin
        w.op = OP_OUT_RD;     w.cond = C_NEVER;       w.target = STEP_IDLE;
      end
      STEP_OUT_WAIT: begin
        w.op = OP_NOP;        w.cond = C_OUT_FULL;    w.target = STEP_OUT_WAIT;
      end
      STEP_OUT_PUSH: begin
        w.op = OP_PUSH;       w.cond = C_MORE_OUT;    w.target = STEP_OUT_RD;
      end
      STEP_FINISH: begin
        w.op = OP_FINISH;     w.cond = C_ALWAYS;      w.target = STEP_IDLE;
      end
      default: begin
        w.op = OP_NOP;        w.cond = C_ALWAYS;      w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // Force a base register into 2..62
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  // Character to digit value; characters outside the alphabet give zero
  function automatic logic [DIGIT_W-1:0] char_to_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) d = c - CHAR_ZERO;
    else if (c >= CHAR_UPA && c <= CHAR_UPZ) d = c - UPPER_OFS;
    else if (c >= CHAR_LOA && c <= CHAR_LOZ) d = c - LOWER_OFS;
    return d[DIGIT_W-1:0];
  endfunction

  // Digit value to character
  function automatic logic [CHAR_W-1:0] value_to_char(input logic [DIGIT_W-1:0] v);
    logic [CHAR_W-1:0] ve;
    ve = {1'b0, v};
    if (v <= LAST_DECIMAL) return ve + CHAR_ZERO;
    if (v <= LAST_UPPER) return ve + UPPER_OFS;
    return ve + LOWER_OFS;
  endfunction

endpackage

FILE: src/rcld_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcld_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 60,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/rcld_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module rcld_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  rcld_pkg::status_t status,
  output rcld_pkg::uword_t  ctl
);

  rcld_pkg::upc_t upc_r;
  rcld_pkg::upc_t upc_nxt;
  logic           take;

  // Decode the current step's control word
  always_comb begin
    ctl = rcld_pkg::ucode(upc_r);
  end

  // Evaluate jump condition and pick next step
  always_comb begin
    unique case (ctl.cond)
      rcld_pkg::C_NEVER:       take = 1'b0;
      rcld_pkg::C_NOT_START:   take = !status.start;
      rcld_pkg::C_DIV_MORE:    take = status.div_more;
      rcld_pkg::C_MORE_DIGITS: take = status.more_digits;
      rcld_pkg::C_PASS_AGAIN:  take = status.pass_again;
      rcld_pkg::C_OUT_FULL:    take = status.out_full;
      rcld_pkg::C_MORE_OUT:    take = status.more_out;
      rcld_pkg::C_ALWAYS:      take = 1'b1;
      default:                 take = 1'b1;
    endcase
    if (take) begin
      upc_nxt = ctl.target;
    end else begin
      upc_nxt = rcld_pkg::upc_t'(upc_r + 4'd1);
    end
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= rcld_pkg::STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: src/radix_converter_long_division.sv
// Top level: radix converter by repeated long division, microcoded datapath.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | in_valid / in_ready     | in_digit_char, in_last_digit
//  out     | output    | out_valid / out_ready   | out_char, out_last, out_too_long
//  cfg     | input     | cfg_we (no wait)        | cfg_index, cfg_wdata
//
// A non-last digit is stored while the sequencer stays idle. The last digit
// starts conversion: each pass loads, divides and stores every stored digit,
// using a restoring divider that retires one quotient bit per cycle.
// Each result character then needs a RAM read, a wait and a load. Reset is
// synchronous; no clearing pass is needed. A stalled output holds the
// sequencer at its wait step; the next number loads while the last one waits.
module radix_converter_long_division #(
  parameter int unsigned MAX_DIGITS     = 10,
  parameter int unsigned MAX_OUT_DIGITS = 60
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [6:0] in_digit_char,
  input  logic       in_last_digit,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_last,
  output logic       out_too_long,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_wdata
);

  localparam int unsigned LEN_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_OUT_DIGITS + 1);
  localparam int unsigned RAM_AW = (MAX_OUT_DIGITS > 1) ? $clog2(MAX_OUT_DIGITS) : 1;
  localparam int unsigned DW     = rcld_pkg::DIGIT_W;
  localparam int unsigned AW     = rcld_pkg::ACC_W;

  rcld_pkg::uword_t  ctl;
  rcld_pkg::status_t status;

  // Configuration and working registers
  logic [rcld_pkg::BASE_W-1:0] sb_r, tb_r;
  logic [DW-1:0]               dig_r [MAX_DIGITS];
  logic [LEN_W-1:0]            len_r, len_nxt;
  logic [LEN_W-1:0]            i_r, i_nxt;
  logic [LEN_W-1:0]            k_r, k_nxt;
  logic                        nz_r, nz_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [DW-1:0]               rem_r, rem_nxt;
  logic [AW-1:0]               acc_r, acc_nxt;
  logic [rcld_pkg::QUO_W-1:0]  q_r, q_nxt;
  logic [rcld_pkg::BIT_W-1:0]  bitcnt_r, bitcnt_nxt;
  logic [CNT_W-1:0]            rcnt_r, rcnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [6:0]                  out_char_r;
  logic                        out_last_r, out_tl_r;

  logic                        dig_we;
  logic [IDX_W-1:0]            dig_waddr;
  logic [DW-1:0]               dig_wdata;

  logic [rcld_pkg::BASE_W-1:0] sb_eff, tb_eff;
  logic [AW-1:0]               mul_w, dshift_w;
  logic                        ge_w;
  logic [CNT_W-1:0]            rd_idx_w;
  logic [DW-1:0]               ram_rdata;
  logic                        ram_we, ram_re;
  logic                        accept_w;

  // Sequencer
  rcld_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  // Remainder store
  rcld_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_OUT_DIGITS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rcnt_r[RAM_AW-1:0]),
    .wdata (rem_r),
    .re    (ram_re),
    .raddr (rd_idx_w[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ready = (ctl.op == rcld_pkg::OP_ACCEPT);
  assign accept_w = in_valid && in_ready;

  assign sb_eff   = rcld_pkg::clamp_base(sb_r);
  assign tb_eff   = rcld_pkg::clamp_base(tb_r);
  assign mul_w    = AW'(rem_r) * AW'(sb_eff);
  assign dshift_w = AW'(tb_eff) << bitcnt_r;
  assign ge_w     = (acc_r >= dshift_w);
  assign rd_idx_w = rcnt_r - CNT_W'(1);
  assign ram_we   = (ctl.op == rcld_pkg::OP_END_PASS);
  assign ram_re   = (ctl.op == rcld_pkg::OP_OUT_RD);

  // Status toward the sequencer
  always_comb begin
    status.start       = in_valid && in_last_digit;
    status.div_more    = (bitcnt_r != '0);
    status.more_digits = (({1'b0, i_r} + 1'b1) < {1'b0, len_r});
    status.pass_again  = (k_r != '0) &&
                         (({1'b0, rcnt_r} + 1'b1) < (CNT_W + 1)'(MAX_OUT_DIGITS));
    status.out_full    = out_valid_r;
    status.more_out    = (rcnt_r != CNT_W'(1));
  end

  // Datapath next values per micro-operation
  always_comb begin
    len_nxt       = len_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    nz_nxt        = nz_r;
    ovf_nxt       = ovf_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    bitcnt_nxt    = bitcnt_r;
    rcnt_nxt      = rcnt_r;
    dig_we        = 1'b0;
    dig_waddr     = len_r[IDX_W-1:0];
    dig_wdata     = rcld_pkg::char_to_value(in_digit_char);
    // drop the output register when taken
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (ctl.op)
      rcld_pkg::OP_ACCEPT: begin
        if (accept_w) begin
          if (len_r < LEN_W'(MAX_DIGITS)) begin
            dig_we  = 1'b1;
            len_nxt = len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      rcld_pkg::OP_PASS_INIT: begin
        rem_nxt = '0;
        i_nxt   = '0;
        k_nxt   = '0;
        nz_nxt  = 1'b0;
      end
      rcld_pkg::OP_LOAD: begin
        acc_nxt    = mul_w + AW'(dig_r[i_r[IDX_W-1:0]]);
        q_nxt      = '0;
        bitcnt_nxt = rcld_pkg::BIT_W'(rcld_pkg::QUO_W - 1);
      end
      rcld_pkg::OP_DIV: begin
        if (ge_w) begin
          acc_nxt = acc_r - dshift_w;
        end
        q_nxt = {q_r[rcld_pkg::QUO_W-2:0], ge_w};
        if (bitcnt_r != '0) begin
          bitcnt_nxt = bitcnt_r - 1'b1;
        end
      end
      rcld_pkg::OP_STORE: begin
        // compact in place: skip leading zero quotient digits
        if (q_r != '0 || nz_r) begin
          dig_we    = 1'b1;
          dig_waddr = k_r[IDX_W-1:0];
          dig_wdata = q_r;
          k_nxt     = k_r + 1'b1;
          nz_nxt    = 1'b1;
        end
        rem_nxt = acc_r[DW-1:0];
        i_nxt   = i_r + 1'b1;
      end
      rcld_pkg::OP_END_PASS: begin
        rcnt_nxt = rcnt_r + 1'b1;
        len_nxt  = k_r;
      end
      rcld_pkg::OP_OUT_RD: begin
      end
      rcld_pkg::OP_PUSH: begin
        out_valid_nxt = 1'b1;
        rcnt_nxt      = rcnt_r - 1'b1;
      end
      rcld_pkg::OP_FINISH: begin
        len_nxt  = '0;
        ovf_nxt  = 1'b0;
        rcnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r        <= rcld_pkg::SOURCE_BASE_RST;
      tb_r        <= rcld_pkg::TARGET_BASE_RST;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == rcld_pkg::REG_SOURCE_BASE) begin
        sb_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == rcld_pkg::REG_TARGET_BASE) begin
        tb_r <= cfg_wdata;
      end
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      rcnt_r      <= rcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    nz_r     <= nz_nxt;
    rem_r    <= rem_nxt;
    acc_r    <= acc_nxt;
    q_r      <= q_nxt;
    bitcnt_r <= bitcnt_nxt;
    if (dig_we) begin
      dig_r[dig_waddr] <= dig_wdata;
    end
    if (ctl.op == rcld_pkg::OP_PUSH) begin
      out_char_r <= rcld_pkg::value_to_char(ram_rdata);
      out_last_r <= (rcnt_r == CNT_W'(1));
      out_tl_r   <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_last     = out_last_r;
  assign out_too_long = out_tl_r;

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_DIGITS))
    else $error("stored digit count beyond limit");

  a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= CNT_W'(MAX_OUT_DIGITS))
    else $error("remainder count beyond limit");

  a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == rcld_pkg::OP_PUSH) |-> !out_valid_r)
    else $error("result loaded over a pending result");

  a_start_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_digit) |=> (ctl.op == rcld_pkg::OP_PASS_INIT))
    else $error("last digit did not start conversion");

endmodule
